// File: sv/pmr_pkg.sv
// shared constants, types and helpers for the ranged park-miller random source
`timescale 1ns / 1ps
`default_nettype none
package pmr_pkg;

	// generator word and range word widths
	localparam int STATE_W = 31;
	localparam int RANGE_W = 32;
	localparam int MULT_W  = 15;
	localparam int PROD_W  = STATE_W + MULT_W;

	// minimal standard multiplier and modulus
	localparam logic [MULT_W-1:0]  PM_MULT = 15'd16807;
	localparam logic [STATE_W-1:0] PM_MOD  = 31'h7FFF_FFFF;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_FIRST  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_SECOND = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SEED_VALUE   = 2'd2;

	// register reset values
	localparam logic [RANGE_W-1:0] RANGE_FIRST_RESET  = 32'd100;
	localparam logic [RANGE_W-1:0] RANGE_SECOND_RESET = 32'd0;
	localparam logic [STATE_W-1:0] SEED_RESET         = 31'd1;

	// default depth of the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// divider steps: one quotient bit of the state per cycle
	localparam int DIV_STEPS = STATE_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

	// range registers as seen by the back end
	typedef struct packed {
		logic [RANGE_W-1:0] range_first;
		logic [RANGE_W-1:0] range_second;
	} range_cfg_t;

	// a zero or all-ones seed would lock the generator, load 1 instead
	function automatic logic [STATE_W-1:0] seed_to_state(input logic [STATE_W-1:0] s);
		logic [STATE_W-1:0] r;
		r = s;
		if (s == '0 || s == PM_MOD) begin
			r = STATE_W'(1);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// File: sv/pmr_front.sv
// front end: config registers, request intake and generator step
`timescale 1ns / 1ps
`default_nettype none
module pmr_front (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [pmr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [pmr_pkg::RANGE_W-1:0]       cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic                              request,
	output pmr_pkg::range_cfg_t                    range_cfg,
	output logic                                   push,
	output logic [pmr_pkg::STATE_W-1:0]            push_data,
	input  wire logic                              queue_full
);

	localparam int STATE_W = pmr_pkg::STATE_W;
	localparam int PROD_W  = pmr_pkg::PROD_W;

	logic [pmr_pkg::RANGE_W-1:0] range_first_q;
	logic [pmr_pkg::RANGE_W-1:0] range_second_q;
	logic [STATE_W-1:0]          lcg_state_q;
	logic                        valid_s1;
	logic [PROD_W-1:0]           prod_s1;
	logic [STATE_W:0]            fold_sum;
	logic [STATE_W-1:0]          next_state;
	logic                        take;

	// one step in flight at a time, the next one needs its new state
	assign in_ready = !valid_s1;
	assign take     = in_valid && in_ready && request;

	// fold the 46-bit product modulo 2^31-1: high part plus low part, one subtract
	always_comb begin
		fold_sum = {1'b0, prod_s1[STATE_W-1:0]} + (STATE_W+1)'(prod_s1[PROD_W-1:STATE_W]);
		if (fold_sum >= {1'b0, pmr_pkg::PM_MOD}) begin
			fold_sum = fold_sum - {1'b0, pmr_pkg::PM_MOD};
		end
		next_state = fold_sum[STATE_W-1:0];
	end

	assign push      = valid_s1 && !queue_full;
	assign push_data = next_state;

	// config registers and generator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_first_q  <= pmr_pkg::RANGE_FIRST_RESET;
			range_second_q <= pmr_pkg::RANGE_SECOND_RESET;
			lcg_state_q    <= pmr_pkg::seed_to_state(pmr_pkg::SEED_RESET);
		end else begin
			if (push) begin
				lcg_state_q <= next_state;
			end
			if (cfg_we) begin
				case (cfg_index)
					pmr_pkg::REG_RANGE_FIRST:  range_first_q  <= cfg_data;
					pmr_pkg::REG_RANGE_SECOND: range_second_q <= cfg_data;
					pmr_pkg::REG_SEED_VALUE:   lcg_state_q    <=
						pmr_pkg::seed_to_state(cfg_data[STATE_W-1:0]);
					default: ;
				endcase
			end
		end
	end

	// multiply stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	// multiply stage payload
	always_ff @(posedge clk) begin
		if (take) begin
			prod_s1 <= PROD_W'(pmr_pkg::PM_MULT) * PROD_W'(lcg_state_q);
		end
	end

	assign range_cfg.range_first  = range_first_q;
	assign range_cfg.range_second = range_second_q;

	// folded state never leaves the generator's cycle
	a_state_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (next_state != '0 && next_state != pmr_pkg::PM_MOD))
		else $error("generator step left the valid state range");

endmodule
`default_nettype wire

// File: sv/pmr_queue.sv
// small fifo of generator states between front and back
`timescale 1ns / 1ps
`default_nettype none
module pmr_queue #(
	parameter int DEPTH = pmr_pkg::QUEUE_DEPTH
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           push,
	input  wire logic [pmr_pkg::STATE_W-1:0]    push_data,
	output logic                                full,
	input  wire logic                           pop,
	output logic [pmr_pkg::STATE_W-1:0]         pop_data,
	output logic                                empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [pmr_pkg::STATE_W-1:0] entry_q [DEPTH];
	logic [PTR_W-1:0]            wr_ptr_q;
	logic [PTR_W-1:0]            rd_ptr_q;
	logic [CNT_W-1:0]            count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = entry_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push && full) |-> 1'b0)
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && empty) |-> 1'b0)
		else $error("queue read while empty");

endmodule
`default_nettype wire

// File: sv/pmr_back.sv
// back end: range ordering, serial modulo and output register
`timescale 1ns / 1ps
`default_nettype none
module pmr_back (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  pmr_pkg::range_cfg_t                 range_cfg,
	input  wire logic                           queue_empty,
	input  wire logic [pmr_pkg::STATE_W-1:0]    queue_data,
	output logic                                pop,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [pmr_pkg::RANGE_W-1:0]         number,
	output logic [pmr_pkg::STATE_W-1:0]         raw_state,
	output logic                                range_empty
);

	localparam int STATE_W = pmr_pkg::STATE_W;
	localparam int RANGE_W = pmr_pkg::RANGE_W;
	localparam int CNT_W   = pmr_pkg::DIV_CNT_W;

	logic                 busy_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [STATE_W-1:0]   state_q;
	logic [STATE_W-1:0]   dividend_q;
	logic [RANGE_W-1:0]   rem_q;
	logic [RANGE_W-1:0]   width_q;
	logic [RANGE_W-1:0]   lo_q;
	logic                 empty_q;
	logic                 out_valid_q;
	logic [RANGE_W-1:0]   lo_c;
	logic [RANGE_W-1:0]   hi_c;
	logic [RANGE_W:0]     trial;
	logic [RANGE_W-1:0]   rem_next;
	logic                 finish;

	// order the range ends
	always_comb begin
		if (range_cfg.range_first > range_cfg.range_second) begin
			hi_c = range_cfg.range_first;
			lo_c = range_cfg.range_second;
		end else begin
			hi_c = range_cfg.range_second;
			lo_c = range_cfg.range_first;
		end
	end

	// one restoring division step
	always_comb begin
		trial = {rem_q, dividend_q[STATE_W-1]};
		if (trial >= {1'b0, width_q}) begin
			trial = trial - {1'b0, width_q};
		end
		rem_next = trial[RANGE_W-1:0];
	end

	assign finish = busy_q && (cnt_q == '0) && (!out_valid_q || out_ready);
	assign pop    = !queue_empty && (!busy_q || finish);

	// divider control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (pop) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(pmr_pkg::DIV_STEPS);
		end else if (finish) begin
			busy_q <= 1'b0;
		end else if (busy_q && cnt_q != '0) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	// divider datapath
	always_ff @(posedge clk) begin
		if (pop) begin
			state_q    <= queue_data;
			dividend_q <= queue_data;
			rem_q      <= '0;
			width_q    <= hi_c - lo_c;
			lo_q       <= lo_c;
			empty_q    <= (hi_c == lo_c);
		end else if (busy_q && cnt_q != '0) begin
			dividend_q <= {dividend_q[STATE_W-2:0], 1'b0};
			rem_q      <= rem_next;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (finish) begin
			number      <= empty_q ? lo_q : lo_q + rem_q;
			raw_state   <= state_q;
			range_empty <= empty_q;
		end
	end

	assign out_valid = out_valid_q;

	a_rem_below_width: assert property (@(posedge clk) disable iff (!arst_n)
		(finish && !empty_q) |-> (rem_q < width_q))
		else $error("remainder not below range width");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		finish |-> (empty_q == (width_q == '0)))
		else $error("empty flag disagrees with range width");

endmodule
`default_nettype wire

// File: sv/park_miller_ranged_random.sv
// top level: ranged park-miller random source
// path from request transfer to result valid: multiply register, queue write, divider load,
// 31 divide steps and output register; a full queue or a held output can stall this path
// the result rate is set by the 31-step one-bit-per-cycle modulo unit, which divides one state at a time
// the multiply and fold front end overlaps the divide through a short state queue
// reset: range ends 100 and 0, generator state 1, queue and output register empty
`timescale 1ns / 1ps
`default_nettype none
module park_miller_ranged_random #(
	parameter int QUEUE_DEPTH = pmr_pkg::QUEUE_DEPTH
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [pmr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [pmr_pkg::RANGE_W-1:0]    cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic                           request,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [pmr_pkg::RANGE_W-1:0]         number,
	output logic [pmr_pkg::STATE_W-1:0]         raw_state,
	output logic                                range_empty
);

	pmr_pkg::range_cfg_t          range_cfg;
	logic                         push;
	logic [pmr_pkg::STATE_W-1:0]  push_data;
	logic                         queue_full;
	logic                         pop;
	logic [pmr_pkg::STATE_W-1:0]  pop_data;
	logic                         queue_empty;

	// intake and generator step
	pmr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.request    (request),
		.range_cfg  (range_cfg),
		.push       (push),
		.push_data  (push_data),
		.queue_full (queue_full)
	);

	// decoupling queue
	pmr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (queue_full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (queue_empty)
	);

	// modulo and output
	pmr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.range_cfg   (range_cfg),
		.queue_empty (queue_empty),
		.queue_data  (pop_data),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.number      (number),
		.raw_state   (raw_state),
		.range_empty (range_empty)
	);

endmodule
`default_nettype wire
